// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the frame receiver.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/frx_pkg.sv =====
// Shared types and constants of the frame receiver with node enrollment.
// Used by the channel interfaces, the front, the queue, the back and the checker.
package frx_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned EV_W   = 2;
    localparam int unsigned SLOT_W = 3;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Event codes carried in the report beat.
    typedef enum logic [EV_W-1:0] {
        EV_PLAIN   = 2'd0,
        EV_NEW     = 2'd1,
        EV_KNOWN   = 2'd2,
        EV_REFUSED = 2'd3
    } t_event;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_FRAME = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op             op;
        logic [BYTE_W-1:0]   fn;
        logic [BYTE_W-1:0]   dv;
        logic [ADDR_W-1:0]   addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/frx_in_if.sv =====
// Input channel of the frame receiver: received bytes and table commands.
// Depends on frx_pkg for the field widths.
interface frx_in_if;
    import frx_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== rtl/frx_out_if.sv =====
// Output channel of the frame receiver: frame reports and ACK frame bytes.
// Depends on frx_pkg for the field widths.
interface frx_out_if;
    import frx_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] function_code;
    logic [BYTE_W-1:0] data_value;
    logic [ADDR_W-1:0] node_address;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;

    modport source (output valid, output kind, output event_res, output function_code,
                    output data_value, output node_address, output slot,
                    output tx_byte, output last, input ready);
    modport sink   (input valid, input kind, input event_res, input function_code,
                    input data_value, input node_address, input slot,
                    input tx_byte, input last, output ready);
endinterface

// ===== rtl/frame_receiver_with_node_enrollment.sv =====
// Top level of the bus-master frame receiver with node enrollment.
// Depends on frx_pkg, frx_in_if, frx_out_if, frx_front, frx_fifo and frx_back.
//
//   Channel  Direction  Beat
//   i_in     sink       mode and rx_byte: a bus byte or a table command
//   o_out    source     frame report, or one byte of the 12-byte ACK frame
//
// The front takes one input beat per cycle while the two-entry command queue
// has room; once the queue is full every input beat waits, frame bytes included.
// The back takes one queued command at a time, searches the table slot by slot
// for an enrollment frame, then sends the output beats of a frame command: a
// report alone, or a report and twelve ACK bytes; open and clear give no beat.
// The output register holds a beat through any stall; reset is synchronous,
// clears control state, empties the queue and leaves the ID table empty.
module frame_receiver_with_node_enrollment #(
    parameter int unsigned FRAME_BYTES = 12,
    parameter int unsigned TABLE_SLOTS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frx_in_if.sink    i_in,
    frx_out_if.source o_out
);
    import frx_pkg::*;

    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    pop_cmd;
    t_q_stat q_stat;

    frx_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    frx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_stat  (q_stat)
    );

    frx_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (pop_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/frx_front.sv =====
// Front part: accepts input beats, collects frame bytes and queues commands.
// Depends on frx_pkg and frx_in_if.
module frx_front #(
    parameter int unsigned FRAME_BYTES = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    frx_in_if.sink          i_in,
    input  frx_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output frx_pkg::t_cmd   o_cmd
);
    import frx_pkg::*;

    localparam int unsigned IDX_W = $clog2(FRAME_BYTES + 1);
    localparam int unsigned FI_W  = $clog2(FRAME_BYTES);

    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_START   = 8'h7E;
    localparam logic [BYTE_W-1:0] SYNC_STOP    = 8'h81;
    localparam logic [BYTE_W-1:0] ORIGIN_SLAVE = 8'h02;

    logic              r_in_frame, n_in_frame;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_frame [FRAME_BYTES];
    logic              store;
    logic              accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_in_frame = r_in_frame;
        n_idx      = r_idx;
        store      = 1'b0;
        o_push     = 1'b0;
        o_cmd.op   = CMD_FRAME;
        o_cmd.fn   = r_frame[6];
        o_cmd.dv   = r_frame[8];
        o_cmd.addr = {r_frame[2], r_frame[3], r_frame[4], r_frame[5]};
        if (accept) begin
            unique case (i_in.mode)
                MODE_OPEN: begin
                    o_push   = 1'b1;
                    o_cmd.op = CMD_OPEN;
                end
                MODE_CLEAR: begin
                    o_push   = 1'b1;
                    o_cmd.op = CMD_CLEAR;
                end
                MODE_BYTE: begin
                    if (!r_in_frame) begin
                        if (i_in.rx_byte == SYNC_START) begin
                            n_in_frame = 1'b1;
                            n_idx      = '0;
                        end
                    end else if (i_in.rx_byte == SYNC_STOP) begin
                        n_in_frame = 1'b0;
                        n_idx      = '0;
                        // Only frames from a slave are handed on.
                        o_push     = (r_frame[7] == ORIGIN_SLAVE);
                    end else if (r_idx < IDX_W'(FRAME_BYTES)) begin
                        store = 1'b1;
                        n_idx = r_idx + IDX_W'(1);
                    end else begin
                        // Overflow drops the frame silently.
                        n_in_frame = 1'b0;
                        n_idx      = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_idx      <= '0;
            for (int k = 0; k < FRAME_BYTES; k++) begin
                r_frame[k] <= '0;
            end
        end else begin
            r_in_frame <= n_in_frame;
            r_idx      <= n_idx;
            if (store) begin
                r_frame[r_idx[FI_W-1:0]] <= i_in.rx_byte;
            end
        end
    end

endmodule

// ===== rtl/frx_fifo.sv =====
// Short command queue between the front and the back.
// Depends on frx_pkg.
module frx_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  frx_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output frx_pkg::t_cmd    o_cmd,
    output frx_pkg::t_q_stat o_stat
);
    import frx_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/frx_back.sv =====
// Back part: table lookup and enrollment, report beat and ACK frame bytes.
// Depends on frx_pkg and frx_out_if.
module frx_back #(
    parameter int unsigned TABLE_SLOTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frx_pkg::t_cmd    i_cmd,
    input  frx_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    frx_out_if.source        o_out
);
    import frx_pkg::*;

    localparam int unsigned NS_W      = $clog2(TABLE_SLOTS + 2);
    localparam int unsigned TI_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned ACK_LEN   = 12;
    localparam int unsigned ACK_IDX_W = $clog2(ACK_LEN);

    localparam logic [BYTE_W-1:0] SYNC_START    = 8'h7E;
    localparam logic [BYTE_W-1:0] SYNC_STOP     = 8'h81;
    localparam logic [BYTE_W-1:0] ACK_CODE      = 8'h06;
    localparam logic [BYTE_W-1:0] FUNC_ENROLL   = 8'h41;
    localparam logic [BYTE_W-1:0] ORIGIN_MASTER = 8'h01;
    localparam logic [BYTE_W-1:0] DEV_ID        = 8'h01;
    localparam logic [BYTE_W-1:0] ACK_LEN_BYTE  = 8'(ACK_LEN);

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TX     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_REPORT = 4'b0100,
        S_ACK    = 4'b1000
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [EV_W-1:0]   event_res;
        logic [BYTE_W-1:0] fn;
        logic [BYTE_W-1:0] dv;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] tx;
        logic              last;
    } t_result;

    function automatic logic [BYTE_W-1:0] ack_byte(
        input logic [ACK_IDX_W-1:0] idx,
        input logic [ADDR_W-1:0]    addr,
        input logic [BYTE_W-1:0]    sl
    );
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] b;
        x = SYNC_START ^ ACK_LEN_BYTE ^ DEV_ID ^ addr[31:24] ^ addr[23:16]
            ^ addr[15:8] ^ addr[7:0] ^ FUNC_ENROLL ^ ORIGIN_MASTER ^ sl;
        unique case (idx)
            4'd0:    b = SYNC_START;
            4'd1:    b = ACK_LEN_BYTE;
            4'd2:    b = DEV_ID;
            4'd3:    b = addr[31:24];
            4'd4:    b = addr[23:16];
            4'd5:    b = addr[15:8];
            4'd6:    b = addr[7:0];
            4'd7:    b = FUNC_ENROLL;
            4'd8:    b = ORIGIN_MASTER;
            4'd9:    b = sl;
            4'd10:   b = ~x;
            4'd11:   b = SYNC_STOP;
            default: b = '0;
        endcase
        return b;
    endfunction

    t_state                 r_state, n_state;
    logic                   r_enroll, n_enroll;
    logic [NS_W-1:0]        r_next, n_next;
    logic [NS_W-1:0]        r_idx, n_idx;
    logic [NS_W-1:0]        r_sl, n_sl;
    t_event                 r_ev, n_ev;
    logic                   r_ack, n_ack;
    logic [ACK_IDX_W-1:0]   r_ack_idx, n_ack_idx;
    logic [BYTE_W-1:0]      r_fn, n_fn;
    logic [BYTE_W-1:0]      r_dv, n_dv;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]      r_table [TABLE_SLOTS];
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;
    logic                   out_free;
    logic                   tbl_we;
    logic [ADDR_W-1:0]      rd_entry;

    // Entries at or beyond the next free slot are never read, so the table
    // needs no clearing.
    assign rd_entry = r_table[TI_W'(r_idx - NS_W'(1))];
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_enroll    = r_enroll;
        n_next      = r_next;
        n_idx       = r_idx;
        n_sl        = r_sl;
        n_ev        = r_ev;
        n_ack       = r_ack;
        n_ack_idx   = r_ack_idx;
        n_fn        = r_fn;
        n_dv        = r_dv;
        n_addr      = r_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        o_pop       = 1'b0;
        tbl_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_OPEN: n_enroll = 1'b1;
                        CMD_CLEAR: begin
                            n_next   = NS_W'(1);
                            n_enroll = 1'b0;
                        end
                        CMD_FRAME: begin
                            n_fn   = i_cmd.fn;
                            n_dv   = i_cmd.dv;
                            n_addr = i_cmd.addr;
                            if (i_cmd.fn == FUNC_ENROLL && i_cmd.addr != '0
                                && i_cmd.dv == ACK_CODE) begin
                                n_idx   = NS_W'(1);
                                n_state = S_SEARCH;
                            end else begin
                                n_ev    = EV_PLAIN;
                                n_sl    = '0;
                                n_ack   = 1'b0;
                                n_state = S_REPORT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_idx < r_next) begin
                    if (rd_entry == r_addr) begin
                        n_sl     = r_idx;
                        n_ev     = EV_KNOWN;
                        n_enroll = 1'b0;
                        n_ack    = 1'b0;
                        n_state  = S_REPORT;
                    end else begin
                        n_idx = r_idx + NS_W'(1);
                    end
                end else if (r_enroll && r_next <= NS_W'(TABLE_SLOTS)) begin
                    n_sl    = r_next;
                    tbl_we  = 1'b1;
                    n_next  = r_next + NS_W'(1);
                    n_ev    = EV_NEW;
                    n_ack   = 1'b1;
                    n_state = S_REPORT;
                end else begin
                    n_sl    = '0;
                    n_ev    = EV_REFUSED;
                    n_ack   = 1'b0;
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_REPORT;
                    n_out.event_res = r_ev;
                    n_out.fn        = r_fn;
                    n_out.dv        = r_dv;
                    n_out.addr      = r_addr;
                    n_out.slot      = SLOT_W'(r_sl);
                    n_out.tx        = '0;
                    n_out.last      = !r_ack;
                    n_ack_idx       = '0;
                    n_state         = r_ack ? S_ACK : S_IDLE;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_TX;
                    n_out.event_res = '0;
                    n_out.fn        = '0;
                    n_out.dv        = '0;
                    n_out.addr      = '0;
                    n_out.slot      = '0;
                    n_out.tx        = ack_byte(r_ack_idx, r_addr, BYTE_W'(r_sl));
                    n_out.last      = (r_ack_idx == ACK_IDX_W'(ACK_LEN - 1));
                    n_ack_idx       = r_ack_idx + ACK_IDX_W'(1);
                    if (r_ack_idx == ACK_IDX_W'(ACK_LEN - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enroll    <= 1'b0;
            r_next      <= NS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enroll    <= n_enroll;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_sl      <= n_sl;
        r_ev      <= n_ev;
        r_ack     <= n_ack;
        r_ack_idx <= n_ack_idx;
        r_fn      <= n_fn;
        r_dv      <= n_dv;
        r_addr    <= n_addr;
        r_out     <= n_out;
        if (tbl_we) begin
            r_table[TI_W'(r_next - NS_W'(1))] <= r_addr;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.event_res     = r_out.event_res;
    assign o_out.function_code = r_out.fn;
    assign o_out.data_value    = r_out.dv;
    assign o_out.node_address  = r_out.addr;
    assign o_out.slot          = r_out.slot;
    assign o_out.tx_byte       = r_out.tx;
    assign o_out.last          = r_out.last;

endmodule

// ===== rtl/frx_checker.sv =====
// Port-level checks on the output channel of the frame receiver, and the
// bind that attaches them. Depends on frx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frx_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_kind,
    input logic [frx_pkg::EV_W-1:0]   i_out_event,
    input logic [frx_pkg::SLOT_W-1:0] i_out_slot,
    input logic [frx_pkg::BYTE_W-1:0] i_out_tx,
    input logic                      i_out_last
);
    import frx_pkg::*;

    // A beat offered during reset must be gone in the next cycle.
    `ASSERT_RST(a_reset_clears_out, i_clk, (!i_rst_n |=> !i_out_valid), "output valid after reset")

    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) && $stable(i_out_tx) && $stable(i_out_last) && $stable(i_out_event)), "stalled beat changed")

    // The beats caused by one input come without gaps.
    `ASSERT_CLK(a_burst_gapless, i_clk, i_rst_n, (i_out_valid && i_out_ready && !i_out_last |=> i_out_valid), "gap inside a result burst")

    // Only a new enrollment is followed by ACK bytes.
    `ASSERT_CLK(a_report_last, i_clk, i_rst_n, (i_out_valid && !i_out_kind |-> (i_out_last == (i_out_event != EV_NEW))), "report last flag wrong")

    `ASSERT_CLK(a_slot_on_hit, i_clk, i_rst_n, (i_out_valid && i_out_slot != '0 |-> !i_out_kind && (i_out_event == EV_NEW || i_out_event == EV_KNOWN)), "slot set without a table hit")

endmodule

bind frame_receiver_with_node_enrollment frx_checker u_frx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_event (o_out.event_res),
    .i_out_slot  (o_out.slot),
    .i_out_tx    (o_out.tx_byte),
    .i_out_last  (o_out.last)
);
